// File: rtl/core/rcs_pkg.sv
package rcs_pkg;

    localparam int TimeoutW = 24;
    localparam int CfgIdxW  = 3;

    localparam logic [TimeoutW-1:0] DefaultTimeoutRst  = 24'd1000;
    localparam logic [TimeoutW-1:0] TxDelayTimeoutRst  = 24'd0;
    localparam logic [TimeoutW-1:0] BufferTimeoutRst   = 24'd1000;
    localparam logic [TimeoutW-1:0] ModeTimeoutRst     = 24'd1000;
    localparam logic [TimeoutW-1:0] TxWaitTimeoutRst   = 24'd10000;
    localparam logic [TimeoutW-1:0] RxWaitTimeoutRst   = 24'd10000;
    localparam logic [TimeoutW-1:0] RxLongTimeoutRst   = 24'd100000;

    localparam logic [15:0] TxBufOffset = 16'd128;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_DEFAULT_TO  = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_TX_DELAY_TO = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_BUFFER_TO   = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_MODE_TO     = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_TX_WAIT_TO  = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_RX_WAIT_TO  = 3'd5;
    localparam logic [CfgIdxW-1:0] CFG_RX_LONG_TO  = 3'd6;
    localparam logic [CfgIdxW-1:0] CFG_FEM_PRESENT = 3'd7;

    // operation types
    localparam logic [2:0] OP_IDLE   = 3'd0;
    localparam logic [2:0] OP_RX     = 3'd1;
    localparam logic [2:0] OP_TX     = 3'd2;
    localparam logic [2:0] OP_CONFIG = 3'd3;
    localparam logic [2:0] OP_MODIFY = 3'd4;

    // transceiver commands
    localparam logic [3:0] CMD_NONE    = 4'd0;
    localparam logic [3:0] CMD_CLRIRQ  = 4'd1;
    localparam logic [3:0] CMD_CLRDIO  = 4'd2;
    localparam logic [3:0] CMD_IDLE    = 4'd3;
    localparam logic [3:0] CMD_RDREG   = 4'd4;
    localparam logic [3:0] CMD_WRREG   = 4'd5;
    localparam logic [3:0] CMD_WRBUF   = 4'd6;
    localparam logic [3:0] CMD_SETTX   = 4'd7;
    localparam logic [3:0] CMD_WAITDIO = 4'd8;
    localparam logic [3:0] CMD_SETRX   = 4'd9;
    localparam logic [3:0] CMD_SETFS   = 4'd10;
    localparam logic [3:0] CMD_PKTSTAT = 4'd11;
    localparam logic [3:0] CMD_RDBUF   = 4'd12;
    localparam logic [3:0] CMD_CUSTOM  = 4'd13;

    localparam logic [1:0] MASK_NONE    = 2'd0;
    localparam logic [1:0] MASK_ALL_DIO = 2'd1;
    localparam logic [1:0] MASK_DIO1    = 2'd2;
    localparam logic [1:0] MASK_ALL_IRQ = 2'd3;

    localparam logic [1:0] FEM_KEEP = 2'd0;
    localparam logic [1:0] FEM_TX   = 2'd1;
    localparam logic [1:0] FEM_RX   = 2'd2;
    localparam logic [1:0] FEM_OFF  = 2'd3;

    typedef enum logic [14:0] {
        PH_START   = 15'b000000000000001,
        PH_RREG    = 15'b000000000000010,
        PH_INIT_TX = 15'b000000000000100,
        PH_WBUF    = 15'b000000000001000,
        PH_CIRQ_TX = 15'b000000000010000,
        PH_CDIO_TX = 15'b000000000100000,
        PH_STX     = 15'b000000001000000,
        PH_WDIO_TX = 15'b000000010000000,
        PH_CIRQ_RX = 15'b000000100000000,
        PH_CDIO_RX = 15'b000001000000000,
        PH_SRX     = 15'b000010000000000,
        PH_WDIO_RX = 15'b000100000000000,
        PH_GPSR    = 15'b001000000000000,
        PH_RBUF    = 15'b010000000000000,
        PH_FINAL   = 15'b100000000000000
    } t_phase;

    typedef struct packed {
        logic                func;
        logic [2:0]          op_type;
        logic                use_tx_delay;
        logic                long_wait;
        logic [15:0]         reg_address;
        logic [7:0]          clear_mask;
        logic [7:0]          set_mask;
        logic [7:0]          tx_size;
        logic [7:0]          rx_size;
        logic [7:0]          cfg_command;
        logic                cmd_ok;
        logic [7:0]          read_data;
    } t_in_item;

    typedef struct packed {
        logic                op_done;
        logic [3:0]          command;
        logic [TimeoutW-1:0] cmd_timeout;
        logic [15:0]         location;
        logic [7:0]          size;
        logic [7:0]          write_data;
        logic [1:0]          mask_select;
        logic [1:0]          fem_mode;
        logic                packet_received;
        logic [2:0]          done_type;
        logic [7:0]          cfg_code;
    } t_result;

    typedef struct packed {
        logic [TimeoutW-1:0] default_to;
        logic [TimeoutW-1:0] tx_delay_to;
        logic [TimeoutW-1:0] buffer_to;
        logic [TimeoutW-1:0] mode_to;
        logic [TimeoutW-1:0] tx_wait_to;
        logic [TimeoutW-1:0] rx_wait_to;
        logic [TimeoutW-1:0] rx_long_to;
        logic                fem_present;
    } t_cfg;

endpackage

// File: rtl/core/rcs_cfg.sv
module rcs_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_wr_en,
    input  logic [rcs_pkg::CfgIdxW-1:0]     i_wr_index,
    input  logic [rcs_pkg::TimeoutW-1:0]    i_wr_data,
    output rcs_pkg::t_cfg                   o_cfg
);
    import rcs_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.default_to  <= DefaultTimeoutRst;
            r_cfg.tx_delay_to <= TxDelayTimeoutRst;
            r_cfg.buffer_to   <= BufferTimeoutRst;
            r_cfg.mode_to     <= ModeTimeoutRst;
            r_cfg.tx_wait_to  <= TxWaitTimeoutRst;
            r_cfg.rx_wait_to  <= RxWaitTimeoutRst;
            r_cfg.rx_long_to  <= RxLongTimeoutRst;
            r_cfg.fem_present <= 1'b0;
        end else if (i_wr_en) begin
            case (i_wr_index)
                CFG_DEFAULT_TO:  r_cfg.default_to  <= i_wr_data;
                CFG_TX_DELAY_TO: r_cfg.tx_delay_to <= i_wr_data;
                CFG_BUFFER_TO:   r_cfg.buffer_to   <= i_wr_data;
                CFG_MODE_TO:     r_cfg.mode_to     <= i_wr_data;
                CFG_TX_WAIT_TO:  r_cfg.tx_wait_to  <= i_wr_data;
                CFG_RX_WAIT_TO:  r_cfg.rx_wait_to  <= i_wr_data;
                CFG_RX_LONG_TO:  r_cfg.rx_long_to  <= i_wr_data;
                CFG_FEM_PRESENT: r_cfg.fem_present <= i_wr_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/core/rcs_seq.sv
module rcs_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_advance,
    input  rcs_pkg::t_in_item i_item,
    input  rcs_pkg::t_cfg     i_cfg,
    output rcs_pkg::t_result  o_res
);
    import rcs_pkg::*;

    t_phase      r_phase, n_phase;
    logic [2:0]  r_held_type, n_held_type;
    logic [15:0] r_held_address, n_held_address;
    logic [7:0]  r_held_clear, n_held_clear;
    logic [7:0]  r_held_set, n_held_set;
    logic [7:0]  r_held_tx_size, n_held_tx_size;
    logic [7:0]  r_held_rx_size, n_held_rx_size;
    logic        r_held_long, n_held_long;
    logic        r_got_packet, n_got_packet;

    t_result     res;
    logic [2:0]  op_t;

    function automatic logic [1:0] fem_sel(input logic present, input logic [1:0] mode);
        fem_sel = present ? mode : FEM_KEEP;
    endfunction

    // unknown operation types run as idle
    assign op_t = (i_item.op_type > OP_MODIFY) ? OP_IDLE : i_item.op_type;

    always_comb begin
        res            = '0;
        n_phase        = r_phase;
        n_held_type    = r_held_type;
        n_held_address = r_held_address;
        n_held_clear   = r_held_clear;
        n_held_set     = r_held_set;
        n_held_tx_size = r_held_tx_size;
        n_held_rx_size = r_held_rx_size;
        n_held_long    = r_held_long;
        n_got_packet   = r_got_packet;

        if (i_item.func) begin
            if (r_phase == PH_START) begin
                n_held_type    = op_t;
                n_held_address = i_item.reg_address;
                n_held_clear   = i_item.clear_mask;
                n_held_set     = i_item.set_mask;
                n_held_tx_size = i_item.tx_size;
                n_held_rx_size = i_item.rx_size;
                n_held_long    = i_item.long_wait;
                n_got_packet   = 1'b0;
                case (op_t)
                    OP_RX: begin
                        res.command     = CMD_CLRIRQ;
                        res.cmd_timeout = i_cfg.default_to;
                        res.mask_select = MASK_ALL_IRQ;
                        n_phase         = PH_CIRQ_RX;
                    end
                    OP_TX: begin
                        if (i_item.use_tx_delay) begin
                            res.command     = CMD_IDLE;
                            res.cmd_timeout = i_cfg.tx_delay_to;
                            n_phase         = PH_INIT_TX;
                        end else begin
                            res.command     = CMD_WRBUF;
                            res.cmd_timeout = i_cfg.buffer_to;
                            res.location    = TxBufOffset;
                            res.size        = i_item.tx_size;
                            n_phase         = PH_WBUF;
                        end
                    end
                    OP_CONFIG: begin
                        if (i_item.cfg_command == 8'd0) begin
                            // empty config finishes at once
                            res.op_done   = 1'b1;
                            res.done_type = op_t;
                            n_phase       = PH_START;
                        end else begin
                            res.command     = CMD_CUSTOM;
                            res.cmd_timeout = i_cfg.default_to;
                            res.cfg_code    = i_item.cfg_command;
                            n_phase         = PH_FINAL;
                        end
                    end
                    OP_MODIFY: begin
                        res.command     = CMD_RDREG;
                        res.cmd_timeout = i_cfg.default_to;
                        res.location    = i_item.reg_address;
                        res.size        = 8'd1;
                        n_phase         = PH_RREG;
                    end
                    default: begin
                        res.command     = CMD_IDLE;
                        res.cmd_timeout = i_cfg.default_to;
                        n_phase         = PH_FINAL;
                    end
                endcase
            end
        end else begin
            case (r_phase)
                PH_START: ;
                PH_RREG: begin
                    if (i_item.cmd_ok) begin
                        res.command     = CMD_WRREG;
                        res.cmd_timeout = i_cfg.default_to;
                        res.location    = r_held_address;
                        res.size        = 8'd1;
                        res.write_data  = (i_item.read_data & ~r_held_clear) | r_held_set;
                        n_phase         = PH_FINAL;
                    end else begin
                        res.op_done   = 1'b1;
                        res.done_type = r_held_type;
                        n_phase       = PH_START;
                    end
                end
                PH_INIT_TX: begin
                    res.command     = CMD_WRBUF;
                    res.cmd_timeout = i_cfg.buffer_to;
                    res.location    = TxBufOffset;
                    res.size        = r_held_tx_size;
                    n_phase         = PH_WBUF;
                end
                PH_WBUF: begin
                    res.command     = CMD_CLRIRQ;
                    res.cmd_timeout = i_cfg.default_to;
                    res.mask_select = MASK_ALL_IRQ;
                    n_phase         = PH_CIRQ_TX;
                end
                PH_CIRQ_TX: begin
                    res.command     = CMD_CLRDIO;
                    res.cmd_timeout = i_cfg.default_to;
                    res.mask_select = MASK_ALL_DIO;
                    n_phase         = PH_CDIO_TX;
                end
                PH_CDIO_TX: begin
                    res.command     = CMD_SETTX;
                    res.cmd_timeout = i_cfg.mode_to;
                    res.fem_mode    = fem_sel(i_cfg.fem_present, FEM_TX);
                    n_phase         = PH_STX;
                end
                PH_STX: begin
                    res.command     = CMD_WAITDIO;
                    res.cmd_timeout = i_cfg.tx_wait_to;
                    res.mask_select = MASK_DIO1;
                    n_phase         = PH_WDIO_TX;
                end
                PH_WDIO_TX: begin
                    res.op_done         = 1'b1;
                    res.done_type       = r_held_type;
                    res.packet_received = r_got_packet && (r_held_type == OP_RX);
                    res.fem_mode        = fem_sel(i_cfg.fem_present, FEM_OFF);
                    n_phase             = PH_START;
                end
                PH_CIRQ_RX: begin
                    res.command     = CMD_CLRDIO;
                    res.cmd_timeout = i_cfg.default_to;
                    res.mask_select = MASK_ALL_DIO;
                    n_phase         = PH_CDIO_RX;
                end
                PH_CDIO_RX: begin
                    res.command     = CMD_SETRX;
                    res.cmd_timeout = i_cfg.mode_to;
                    res.fem_mode    = fem_sel(i_cfg.fem_present, FEM_RX);
                    n_phase         = PH_SRX;
                end
                PH_SRX: begin
                    res.command     = CMD_WAITDIO;
                    res.cmd_timeout = r_held_long ? i_cfg.rx_long_to : i_cfg.rx_wait_to;
                    res.mask_select = MASK_DIO1;
                    n_phase         = PH_WDIO_RX;
                end
                PH_WDIO_RX: begin
                    res.fem_mode = fem_sel(i_cfg.fem_present, FEM_OFF);
                    if (i_item.cmd_ok) begin
                        n_got_packet    = 1'b1;
                        res.command     = CMD_PKTSTAT;
                        res.cmd_timeout = i_cfg.default_to;
                        n_phase         = PH_GPSR;
                    end else begin
                        // receive wait failed: fall back to fs
                        n_got_packet    = 1'b0;
                        res.command     = CMD_SETFS;
                        res.cmd_timeout = i_cfg.mode_to;
                        n_phase         = PH_FINAL;
                    end
                end
                PH_GPSR: begin
                    res.command     = CMD_RDBUF;
                    res.cmd_timeout = i_cfg.buffer_to;
                    res.location    = 16'd0;
                    res.size        = r_held_rx_size;
                    n_phase         = PH_RBUF;
                end
                default: begin
                    res.op_done         = 1'b1;
                    res.done_type       = r_held_type;
                    res.packet_received = r_got_packet && (r_held_type == OP_RX);
                    n_phase             = PH_START;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_START;
            r_held_type  <= OP_IDLE;
            r_got_packet <= 1'b0;
        end else if (i_advance) begin
            r_phase      <= n_phase;
            r_held_type  <= n_held_type;
            r_got_packet <= n_got_packet;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_address <= '0;
            r_held_clear   <= '0;
            r_held_set     <= '0;
            r_held_tx_size <= '0;
            r_held_rx_size <= '0;
            r_held_long    <= 1'b0;
        end else if (i_advance) begin
            r_held_address <= n_held_address;
            r_held_clear   <= n_held_clear;
            r_held_set     <= n_held_set;
            r_held_tx_size <= n_held_tx_size;
            r_held_rx_size <= n_held_rx_size;
            r_held_long    <= n_held_long;
        end
    end

    assign o_res = res;

endmodule

// File: rtl/core/radio_phy_command_sequencer_unit.sv
// Transceiver command sequencer, one radio operation at a time.
// Input stream s_axis: tuser = 1 for a new operation request, 0 for a
// command-done event (cmd_ok, read_data). Requests are honored only between
// operations; an item out of place still yields one all-zero result.
// Output stream m_axis: exactly one result per input item, in order. tuser is
// op_done; tdata carries the next command with its timeout and arguments.
// Configuration channel: i_cfg_valid/o_cfg_ready with a 3-bit register index
// and 24-bit data; always ready, write only while no item is in flight.
// Path: an accepted item lands in the input register, is decided against
// the phase register and is registered into the result register that drives
// m_axis; while m_axis stalls it waits in the input register.
// Throughput is one item per cycle while m_axis does not stall; the
// phase/operand registers and the result register advance together.
// Reset (synchronous, active low) returns the phase to start, loads the
// register defaults and empties both stages.
// When m_axis stalls, the result register holds and the input register fills;
// s_axis_tready then drops until the result is taken, so nothing is lost.
module radio_phy_command_sequencer_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // op_type[2:0], use_tx_delay[3], long_wait[4], reg_address[20:5],
    // clear_mask[28:21], set_mask[36:29], tx_size[44:37], rx_size[52:45],
    // cfg_command[60:53], cmd_ok[61], read_data[69:62], zero[71:70]
    input  logic [71:0]                   s_axis_tdata,
    // func[0]
    input  logic                          s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // command[3:0], cmd_timeout[27:4], location[43:28], size[51:44],
    // write_data[59:52], mask_select[61:60], fem_mode[63:62],
    // packet_received[64], done_type[67:65], cfg_code[75:68], zero[79:76]
    output logic [79:0]                   m_axis_tdata,
    // op_done[0]
    output logic                          m_axis_tuser,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [rcs_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  logic [rcs_pkg::TimeoutW-1:0]  i_cfg_data
);
    import rcs_pkg::*;

    t_cfg     cfg;
    t_in_item in_item;
    t_result  res;

    logic     r_in_valid;
    t_in_item r_in_item;
    logic     r_out_valid;
    t_result  r_out_res;
    logic     out_free;
    logic     advance;

    assign o_cfg_ready = 1'b1;

    rcs_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    assign in_item.func         = s_axis_tuser;
    assign in_item.op_type      = s_axis_tdata[2:0];
    assign in_item.use_tx_delay = s_axis_tdata[3];
    assign in_item.long_wait    = s_axis_tdata[4];
    assign in_item.reg_address  = s_axis_tdata[20:5];
    assign in_item.clear_mask   = s_axis_tdata[28:21];
    assign in_item.set_mask     = s_axis_tdata[36:29];
    assign in_item.tx_size      = s_axis_tdata[44:37];
    assign in_item.rx_size      = s_axis_tdata[52:45];
    assign in_item.cfg_command  = s_axis_tdata[60:53];
    assign in_item.cmd_ok       = s_axis_tdata[61];
    assign in_item.read_data    = s_axis_tdata[69:62];

    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;

    rcs_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (r_in_item),
        .i_cfg     (cfg),
        .o_res     (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_item <= in_item;
        end
        if (advance) begin
            r_out_res <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_res.op_done;
    assign m_axis_tdata  = {4'd0,
                            r_out_res.cfg_code,
                            r_out_res.done_type,
                            r_out_res.packet_received,
                            r_out_res.fem_mode,
                            r_out_res.mask_select,
                            r_out_res.write_data,
                            r_out_res.size,
                            r_out_res.location,
                            r_out_res.cmd_timeout,
                            r_out_res.command};

endmodule

// File: rtl/core/rcs_chk.sv
module rcs_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [79:0]                   m_axis_tdata,
    input logic                          m_axis_tuser
);
    import rcs_pkg::*;

    // output stage is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // a finished operation never issues a command in the same result
    a_done_no_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[3:0] == CMD_NONE)
        else $error("command issued with op_done");

    a_clrirq_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[3:0] == CMD_CLRIRQ |->
            m_axis_tdata[61:60] == MASK_ALL_IRQ)
        else $error("clear irq without full mask");

    a_pkt_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[64] |->
            m_axis_tuser && m_axis_tdata[67:65] == OP_RX)
        else $error("packet flag outside a finished receive");

endmodule

bind radio_phy_command_sequencer_unit rcs_chk u_rcs_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// File: dv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rcs_pkg::*;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idling;
    typedef enum int {OK_RANDOM, OK_ALL, OK_FAIL} t_ok_mode;

    localparam int ItemsPerPhase = 225;
    localparam int NumPhases     = 8;
    localparam int MaxPrinted    = 40;

    class command_scoreboard;
        t_cfg        cfg;
        t_phase      phase;
        logic [2:0]  held_type;
        logic [15:0] held_address;
        logic [7:0]  held_clear;
        logic [7:0]  held_set;
        logic [7:0]  held_tx_size;
        logic [7:0]  held_rx_size;
        logic        held_long;
        logic        got_packet;
        t_result     expected_cmds[$];
        int          n_errors;
        int          n_results;

        function new();
            cfg.default_to  = DefaultTimeoutRst;
            cfg.tx_delay_to = TxDelayTimeoutRst;
            cfg.buffer_to   = BufferTimeoutRst;
            cfg.mode_to     = ModeTimeoutRst;
            cfg.tx_wait_to  = TxWaitTimeoutRst;
            cfg.rx_wait_to  = RxWaitTimeoutRst;
            cfg.rx_long_to  = RxLongTimeoutRst;
            cfg.fem_present = 1'b0;
            phase        = PH_START;
            held_type    = OP_IDLE;
            held_address = '0;
            held_clear   = '0;
            held_set     = '0;
            held_tx_size = '0;
            held_rx_size = '0;
            held_long    = 1'b0;
            got_packet   = 1'b0;
            n_errors     = 0;
            n_results    = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [23:0] v);
            case (idx)
                CFG_DEFAULT_TO:  cfg.default_to  = v;
                CFG_TX_DELAY_TO: cfg.tx_delay_to = v;
                CFG_BUFFER_TO:   cfg.buffer_to   = v;
                CFG_MODE_TO:     cfg.mode_to     = v;
                CFG_TX_WAIT_TO:  cfg.tx_wait_to  = v;
                CFG_RX_WAIT_TO:  cfg.rx_wait_to  = v;
                CFG_RX_LONG_TO:  cfg.rx_long_to  = v;
                default:         cfg.fem_present = v[0];
            endcase
        endfunction

        function t_result cmd_out(logic [3:0] c, logic [23:0] to, t_phase nxt);
            t_result r;
            r = '0;
            r.command     = c;
            r.cmd_timeout = to;
            phase         = nxt;
            return r;
        endfunction

        function t_result wrbuf_out();
            t_result r;
            r = cmd_out(CMD_WRBUF, cfg.buffer_to, PH_WBUF);
            r.location = TxBufOffset;
            r.size     = held_tx_size;
            return r;
        endfunction

        function t_result finish_op();
            t_result r;
            r = '0;
            r.op_done         = 1'b1;
            r.done_type       = held_type;
            r.packet_received = got_packet && held_type == OP_RX;
            phase             = PH_START;
            return r;
        endfunction

        function logic [1:0] fem(logic [1:0] m);
            return cfg.fem_present ? m : FEM_KEEP;
        endfunction

        function t_result next_command(t_in_item it);
            t_result r;
            r = '0;
            if (it.func) begin
                // requests are only taken between operations
                if (phase != PH_START)
                    return r;
                held_type    = (it.op_type > OP_MODIFY) ? OP_IDLE : it.op_type;
                held_address = it.reg_address;
                held_clear   = it.clear_mask;
                held_set     = it.set_mask;
                held_tx_size = it.tx_size;
                held_rx_size = it.rx_size;
                held_long    = it.long_wait;
                got_packet   = 1'b0;
                case (held_type)
                    OP_RX: begin
                        r = cmd_out(CMD_CLRIRQ, cfg.default_to, PH_CIRQ_RX);
                        r.mask_select = MASK_ALL_IRQ;
                    end
                    OP_TX: begin
                        if (it.use_tx_delay)
                            r = cmd_out(CMD_IDLE, cfg.tx_delay_to, PH_INIT_TX);
                        else
                            r = wrbuf_out();
                    end
                    OP_CONFIG: begin
                        if (it.cfg_command == '0) begin
                            r = finish_op();
                        end else begin
                            r = cmd_out(CMD_CUSTOM, cfg.default_to, PH_FINAL);
                            r.cfg_code = it.cfg_command;
                        end
                    end
                    OP_MODIFY: begin
                        r = cmd_out(CMD_RDREG, cfg.default_to, PH_RREG);
                        r.location = held_address;
                        r.size     = 8'd1;
                    end
                    default: r = cmd_out(CMD_IDLE, cfg.default_to, PH_FINAL);
                endcase
                return r;
            end
            case (phase)
                PH_START: r = '0;
                PH_RREG: begin
                    if (it.cmd_ok) begin
                        r = cmd_out(CMD_WRREG, cfg.default_to, PH_FINAL);
                        r.location   = held_address;
                        r.size       = 8'd1;
                        r.write_data = (it.read_data & ~held_clear) | held_set;
                    end else begin
                        r = finish_op();
                    end
                end
                PH_INIT_TX: r = wrbuf_out();
                PH_WBUF: begin
                    r = cmd_out(CMD_CLRIRQ, cfg.default_to, PH_CIRQ_TX);
                    r.mask_select = MASK_ALL_IRQ;
                end
                PH_CIRQ_TX: begin
                    r = cmd_out(CMD_CLRDIO, cfg.default_to, PH_CDIO_TX);
                    r.mask_select = MASK_ALL_DIO;
                end
                PH_CDIO_TX: begin
                    r = cmd_out(CMD_SETTX, cfg.mode_to, PH_STX);
                    r.fem_mode = fem(FEM_TX);
                end
                PH_STX: begin
                    r = cmd_out(CMD_WAITDIO, cfg.tx_wait_to, PH_WDIO_TX);
                    r.mask_select = MASK_DIO1;
                end
                PH_WDIO_TX: begin
                    r = finish_op();
                    r.fem_mode = fem(FEM_OFF);
                end
                PH_CIRQ_RX: begin
                    r = cmd_out(CMD_CLRDIO, cfg.default_to, PH_CDIO_RX);
                    r.mask_select = MASK_ALL_DIO;
                end
                PH_CDIO_RX: begin
                    r = cmd_out(CMD_SETRX, cfg.mode_to, PH_SRX);
                    r.fem_mode = fem(FEM_RX);
                end
                PH_SRX: begin
                    r = cmd_out(CMD_WAITDIO, held_long ? cfg.rx_long_to : cfg.rx_wait_to,
                                PH_WDIO_RX);
                    r.mask_select = MASK_DIO1;
                end
                PH_WDIO_RX: begin
                    // a failed wait drops to fs and reports no packet
                    got_packet = it.cmd_ok;
                    if (it.cmd_ok)
                        r = cmd_out(CMD_PKTSTAT, cfg.default_to, PH_GPSR);
                    else
                        r = cmd_out(CMD_SETFS, cfg.mode_to, PH_FINAL);
                    r.fem_mode = fem(FEM_OFF);
                end
                PH_GPSR: begin
                    r = cmd_out(CMD_RDBUF, cfg.buffer_to, PH_RBUF);
                    r.location = '0;
                    r.size     = held_rx_size;
                end
                default: r = finish_op();
            endcase
            return r;
        endfunction

        function void note_item(t_in_item it);
            expected_cmds.push_back(next_command(it));
        endfunction

        task report(string msg);
            if (n_errors < MaxPrinted)
                $display("%0t mismatch: %s", $realtime, msg);
            n_errors++;
        endtask

        task cmp(string name, logic [23:0] got, logic [23:0] want);
            if (got !== want)
                report($sformatf("result %0d field %s is 0x%0h, predicted 0x%0h",
                                 n_results, name, got, want));
        endtask

        task check_result(t_result got);
            t_result want;
            n_results++;
            if (expected_cmds.size() == 0) begin
                report($sformatf("result %0d arrived with nothing predicted", n_results));
                return;
            end
            want = expected_cmds.pop_front();
            cmp("op_done", 24'(got.op_done), 24'(want.op_done));
            cmp("command", 24'(got.command), 24'(want.command));
            cmp("cmd_timeout", got.cmd_timeout, want.cmd_timeout);
            cmp("location", 24'(got.location), 24'(want.location));
            cmp("size", 24'(got.size), 24'(want.size));
            cmp("write_data", 24'(got.write_data), 24'(want.write_data));
            cmp("mask_select", 24'(got.mask_select), 24'(want.mask_select));
            cmp("fem_mode", 24'(got.fem_mode), 24'(want.fem_mode));
            cmp("packet_received", 24'(got.packet_received), 24'(want.packet_received));
            cmp("done_type", 24'(got.done_type), 24'(want.done_type));
            cmp("cfg_code", 24'(got.cfg_code), 24'(want.cfg_code));
        endtask
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [71:0]         s_axis_tdata;
    logic                s_axis_tuser;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [79:0]         m_axis_tdata;
    logic                m_axis_tuser;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [CfgIdxW-1:0]  i_cfg_index;
    logic [TimeoutW-1:0] i_cfg_data;

    command_scoreboard model = new();
    t_idling           idling;
    t_result           seen;
    int                n_items;

    radio_phy_command_sequencer_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // receiver back-pressure
    always @(negedge i_clk) begin
        case (idling)
            IDLE_RECEIVER: m_axis_tready <= $urandom_range(99) >= 45;
            IDLE_BOTH:     m_axis_tready <= $urandom_range(99) >= 8;
            default:       m_axis_tready <= 1'b1;
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen.op_done         = m_axis_tuser;
            seen.command         = m_axis_tdata[3:0];
            seen.cmd_timeout     = m_axis_tdata[27:4];
            seen.location        = m_axis_tdata[43:28];
            seen.size            = m_axis_tdata[51:44];
            seen.write_data      = m_axis_tdata[59:52];
            seen.mask_select     = m_axis_tdata[61:60];
            seen.fem_mode        = m_axis_tdata[63:62];
            seen.packet_received = m_axis_tdata[64];
            seen.done_type       = m_axis_tdata[67:65];
            seen.cfg_code        = m_axis_tdata[75:68];
            model.check_result(seen);
        end
    end

    function automatic t_in_item rand_item(logic f);
        t_in_item    it;
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        it = raw[$bits(t_in_item)-1:0];
        it.func = f;
        // mostly known operation types, some out of range
        it.op_type = ($urandom_range(99) < 85) ? 3'($urandom_range(4))
                                               : 3'($urandom_range(7, 5));
        if ($urandom_range(4) == 0)
            it.cfg_command = '0;
        return it;
    endfunction

    task automatic send_item(t_in_item it);
        int gap_pct;
        gap_pct = (idling == IDLE_SENDER) ? 45 : (idling == IDLE_BOTH) ? 8 : 0;
        while ($urandom_range(99) < gap_pct) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.func;
        s_axis_tdata  <= {2'b00, it.read_data, it.cmd_ok, it.cfg_command, it.rx_size,
                          it.tx_size, it.set_mask, it.clear_mask, it.reg_address,
                          it.long_wait, it.use_tx_delay, it.op_type};
        do @(posedge i_clk); while (!s_axis_tready);
        model.note_item(it);
        n_items++;
    endtask

    // one operation from its request until the sequencer is back at start
    task automatic run_op(t_in_item req, t_ok_mode mode, bit noisy);
        t_in_item ev;
        send_item(req);
        while (model.phase != PH_START) begin
            ev = rand_item(1'b0);
            if (noisy && $urandom_range(99) < 6)
                ev.func = 1'b1;
            else if (mode == OK_ALL)
                ev.cmd_ok = 1'b1;
            else if (mode == OK_FAIL)
                ev.cmd_ok = 1'b0;
            else
                ev.cmd_ok = $urandom_range(99) < 70;
            send_item(ev);
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (model.expected_cmds.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [23:0] v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        model.set_reg(idx, v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic load_settings(int p);
        logic [23:0] v;
        for (int k = CFG_DEFAULT_TO; k <= CFG_FEM_PRESENT; k++) begin
            case (p)
                1: v = '1;
                2: v = (k == CFG_FEM_PRESENT) ? 24'hFFFFFE : '0;
                3: v = (k == CFG_FEM_PRESENT) ? 24'h000001 : 24'($urandom);
                default: begin
                    case ($urandom_range(4))
                        0:       v = '0;
                        1:       v = '1;
                        default: v = 24'($urandom);
                    endcase
                end
            endcase
            write_reg(3'(k), v);
        end
    endtask

    task automatic directed();
        t_in_item it;
        // unknown operation type with every request field at its maximum
        it = '1;
        run_op(it, OK_FAIL, 1'b0);
        // command-done while nothing runs
        it = '1;
        it.func = 1'b0;
        send_item(it);
        // read-modify-write, then one whose read fails
        it = '0;
        it.func        = 1'b1;
        it.op_type     = OP_MODIFY;
        it.reg_address = 16'hFFFF;
        it.clear_mask  = 8'hF0;
        it.set_mask    = 8'h0C;
        run_op(it, OK_ALL, 1'b0);
        it.reg_address = '0;
        run_op(it, OK_FAIL, 1'b0);
        // empty config finishes at once
        it = '0;
        it.func    = 1'b1;
        it.op_type = OP_CONFIG;
        send_item(it);
        // custom command with a stray request in the middle
        it.cfg_command = 8'hFF;
        send_item(it);
        send_item(it);
        it = '0;
        it.cmd_ok = 1'b1;
        send_item(it);
        // delayed transmit, every command failing
        it = '0;
        it.func         = 1'b1;
        it.op_type      = OP_TX;
        it.use_tx_delay = 1'b1;
        it.tx_size      = 8'hFF;
        run_op(it, OK_FAIL, 1'b0);
        // receive with long wait and a packet, then a receive whose wait fails
        it = '0;
        it.func      = 1'b1;
        it.op_type   = OP_RX;
        it.long_wait = 1'b1;
        it.rx_size   = 8'hFF;
        run_op(it, OK_ALL, 1'b0);
        it.long_wait = 1'b0;
        run_op(it, OK_FAIL, 1'b0);
    endtask

    initial begin
        #5ms;
        $display("[radio_phy_command_sequencer_unit] ERROR");
        $finish;
    end

    initial begin
        int  target;
        bit  paused;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b1;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        idling        = IDLE_NONE;
        n_items       = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int p = 0; p < NumPhases; p++) begin
            idling = t_idling'(p % 4);
            if (p == 0)
                directed();
            else
                load_settings(p);
            target = n_items + ItemsPerPhase;
            paused = 1'b0;
            while (n_items < target) begin
                if ($urandom_range(99) < 8)
                    send_item(rand_item(1'b0));
                else
                    run_op(rand_item(1'b1), OK_RANDOM, 1'b1);
                // hold off once per phase until the pipeline is empty
                if (!paused && n_items >= target - ItemsPerPhase / 2) begin
                    drain();
                    paused = 1'b1;
                end
            end
            drain();
        end

        if (model.expected_cmds.size() != 0)
            model.report("predicted results never arrived");
        if (model.n_errors == 0)
            $display("[radio_phy_command_sequencer_unit] OK");
        else
            $display("[radio_phy_command_sequencer_unit] ERROR");
        $finish;
    end

endmodule

// File: radio_phy_command_sequencer_unit.f
rtl/core/rcs_pkg.sv
rtl/core/rcs_cfg.sv
rtl/core/rcs_seq.sv
rtl/core/radio_phy_command_sequencer_unit.sv
rtl/core/rcs_chk.sv
dv/testbench.sv
